// ===== src/assert_macros.svh =====
// Assertion macros shared by the pixel mapper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold too.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/dupml_pkg.sv =====
// Types and constants shared by the pixel mapper modules.
`default_nettype none

package dupml_pkg;

  // Input word kinds carried on s_axis_tuser
  typedef enum logic [1:0] {
    ACT_PIXEL = 2'd0,
    ACT_SYNC  = 2'd1,
    ACT_TICK  = 2'd2
  } action_t;

  // Latch modes
  typedef enum logic [1:0] {
    MODE_TIMED  = 2'd0,
    MODE_SYNC   = 2'd1,
    MODE_TEST_A = 2'd2,
    MODE_TEST_B = 2'd3
  } mode_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_RUN_MODE    = 2'd0,
    REG_UPO         = 2'd1,
    REG_START_UNIV  = 2'd2,
    REG_UPDATE_RATE = 2'd3
  } reg_index_t;

  // Output word kinds carried on m_axis_tuser
  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_LATCH = 1'b1
  } kind_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_EMIT = 2'd2
  } state_t;

  localparam int          CH_PER_PIXEL = 3;
  localparam int          MS_PER_S     = 1000;
  localparam logic [9:0]  DEFAULT_RATE = 10'd60;
  localparam logic [15:0] ELAPSED_MAX  = 16'hFFFF;
  localparam int          UPO_MAX_CODE = 7;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic commit;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic has_result;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

// ===== src/dmx_universe_pixel_mapper_latch.sv =====
// Top level of the DMX universe pixel mapper with frame latch.
// Input stream: one word per pixel, sync event or one millisecond tick; s_axis_tuser
//   carries the word kind, s_axis_tdata the pixel fields.
// Output stream: frame buffer pixel writes and frame latch commands; m_axis_tuser
//   carries the kind, m_axis_tdata the address and colour.
// Config channel: cfg_valid/cfg_index/cfg_data, always ready; write only while idle.
// Each word goes through accept, compute (one address multiply and one elapsed-time
//   multiply) and commit, which writes any result into the output register; the
//   next word is accepted in the cycle after commit.
// The output register parts the two sides: a new word is accepted while a result
//   waits, and the commit step holds only if that word also yields a result
//   while the receiver still stalls the previous one.
// Sync events, ticks that do not latch and dropped pixels produce no output word.
// Reset restores the register defaults (sync mode, one universe per output, start
//   universe 0, rate 0 taken as 60 Hz), clears the elapsed counter and both flags and empties
//   the output register.
`default_nettype none

module dmx_universe_pixel_mapper_latch #(
  parameter int NUM_OUTPUTS              = 8,
  parameter int PIXELS_PER_UNIVERSE      = 170,
  parameter int MAX_UNIVERSES_PER_OUTPUT = 4
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // universe[14:0], pixel_index[22:15], channel_count[32:23], red_in[40:33],
  // green_in[48:41], blue_in[56:49], zero[63:57]
  input  wire  [63:0] s_axis_tdata,
  // action[1:0]
  input  wire  [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // pixel_address[12:0], red_out[20:13], green_out[28:21], blue_out[36:29], zero[39:37]
  output logic [39:0] m_axis_tdata,
  // result_kind[0]
  output logic [0:0]  m_axis_tuser,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [14:0] cfg_data
);

  dupml_pkg::cmd_t    cmd;
  dupml_pkg::status_t status;

  assign cfg_ready = 1'b1;

  dupml_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status        (status),
    .cmd           (cmd)
  );

  dupml_datapath #(
    .NUM_OUTPUTS              (NUM_OUTPUTS),
    .PIXELS_PER_UNIVERSE      (PIXELS_PER_UNIVERSE),
    .MAX_UNIVERSES_PER_OUTPUT (MAX_UNIVERSES_PER_OUTPUT)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ===== src/dupml_ctrl.sv =====
// Controller state machine sequencing one word through accept, compute and commit.
`default_nettype none
`include "assert_macros.svh"

module dupml_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  s_axis_tvalid,
  output logic                 s_axis_tready,
  input  dupml_pkg::status_t   status,
  output dupml_pkg::cmd_t      cmd
);

  dupml_pkg::state_t state;
  dupml_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dupml_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      dupml_pkg::ST_IDLE: begin
        if (s_axis_tvalid) state_next = dupml_pkg::ST_EXEC;
      end
      dupml_pkg::ST_EXEC: begin
        state_next = dupml_pkg::ST_EMIT;
      end
      dupml_pkg::ST_EMIT: begin
        // hold while a result has nowhere to go
        if (!(status.has_result && status.out_busy)) state_next = dupml_pkg::ST_IDLE;
      end
      default: begin
        state_next = dupml_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    s_axis_tready = 1'b0;
    cmd           = '0;
    unique case (state)
      dupml_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd.load      = s_axis_tvalid;
      end
      dupml_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      dupml_pkg::ST_EMIT: begin
        cmd.commit = !(status.has_result && status.out_busy);
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  `ASSERT_NEXT(a_accept_exec, clk, rst, s_axis_tvalid && s_axis_tready, state == dupml_pkg::ST_EXEC, "accepted word did not enter compute")
  `ASSERT_IMPLIES(a_no_commit_busy, clk, rst, cmd.commit, !(status.has_result && status.out_busy), "commit while output register is blocked")

endmodule

`default_nettype wire

// ===== src/dupml_datapath.sv =====
// Datapath: configuration, word registers, address and latch arithmetic, output register.
`default_nettype none
`include "assert_macros.svh"

module dupml_datapath #(
  parameter int NUM_OUTPUTS              = 8,
  parameter int PIXELS_PER_UNIVERSE      = 170,
  parameter int MAX_UNIVERSES_PER_OUTPUT = 4
) (
  input  wire                 clk,
  input  wire                 rst,
  input  dupml_pkg::cmd_t     cmd,
  output dupml_pkg::status_t  status,
  input  wire  [63:0]         s_axis_tdata,
  input  wire  [1:0]          s_axis_tuser,
  input  wire                 cfg_valid,
  input  wire  [1:0]          cfg_index,
  input  wire  [14:0]         cfg_data,
  input  wire                 m_axis_tready,
  output logic                m_axis_tvalid,
  output logic [39:0]         m_axis_tdata,
  output logic [0:0]          m_axis_tuser
);

  localparam int UPO_CAP = (MAX_UNIVERSES_PER_OUTPUT < dupml_pkg::UPO_MAX_CODE) ?
                           MAX_UNIVERSES_PER_OUTPUT : dupml_pkg::UPO_MAX_CODE;
  localparam int LIM_W   = $clog2(NUM_OUTPUTS * UPO_CAP + 1);
  localparam int TP_W    = 27;

  // Configuration registers
  logic [1:0]  run_mode;
  logic [2:0]  upo;
  logic [14:0] start_universe;
  logic [9:0]  update_rate_hz;

  // Latch state
  logic [15:0] ms_since_latch;
  logic        frame_dirty;
  logic        sync_seen;

  // Captured word
  logic [1:0]  it_action;
  logic [14:0] it_universe;
  logic [7:0]  it_index;
  logic [9:0]  it_count;
  logic [7:0]  it_red;
  logic [7:0]  it_green;
  logic [7:0]  it_blue;

  // Compute stage results
  logic            ex_in_range;
  logic            ex_idx_ok;
  logic [12:0]     ex_addr_base;
  logic [15:0]     ex_ms_inc;
  logic [TP_W-1:0] ex_time_prod;

  // Output register
  logic        out_kind;
  logic [12:0] out_addr;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;

  logic [2:0]       upo_eff;
  logic [LIM_W-1:0] lim;
  logic [14:0]      rel;
  logic             below;
  logic [10:0]      need_ch;
  logic [15:0]      ms_inc;
  logic [9:0]       rate_eff;
  logic [12:0]      addr;
  logic             elapsed;
  logic             latch;
  logic             pix_ok;
  logic             has_result;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode       <= dupml_pkg::MODE_SYNC;
      upo            <= 3'd1;
      start_universe <= '0;
      update_rate_hz <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        dupml_pkg::REG_RUN_MODE:    run_mode       <= cfg_data[1:0];
        dupml_pkg::REG_UPO:         upo            <= cfg_data[2:0];
        dupml_pkg::REG_START_UNIV:  start_universe <= cfg_data[14:0];
        dupml_pkg::REG_UPDATE_RATE: update_rate_hz <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  // Capture accepted word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_action   <= s_axis_tuser;
      it_universe <= s_axis_tdata[14:0];
      it_index    <= s_axis_tdata[22:15];
      it_count    <= s_axis_tdata[32:23];
      it_red      <= s_axis_tdata[40:33];
      it_green    <= s_axis_tdata[48:41];
      it_blue     <= s_axis_tdata[56:49];
    end
  end

  // Mapping arithmetic; output*strip_len + segment*ppu equals rel*ppu
  always_comb begin
    if (upo == 3'd0) begin
      upo_eff = 3'd1;
    end else if (upo > 3'(UPO_CAP)) begin
      upo_eff = 3'(UPO_CAP);
    end else begin
      upo_eff = upo;
    end
    lim      = LIM_W'(NUM_OUTPUTS) * LIM_W'(upo_eff);
    below    = it_universe < start_universe;
    rel      = it_universe - start_universe;
    need_ch  = (11'(it_index) + 11'd1) * 11'(dupml_pkg::CH_PER_PIXEL);
    ms_inc   = (ms_since_latch == dupml_pkg::ELAPSED_MAX) ? ms_since_latch :
               ms_since_latch + 16'd1;
    rate_eff = (update_rate_hz == 10'd0) ? dupml_pkg::DEFAULT_RATE : update_rate_hz;
  end

  // Compute stage registers
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ex_in_range  <= !below && (rel < 15'(lim));
      ex_idx_ok    <= (it_index < 8'(PIXELS_PER_UNIVERSE)) && (need_ch <= 11'(it_count));
      ex_addr_base <= rel[12:0] * 13'(PIXELS_PER_UNIVERSE);
      ex_ms_inc    <= ms_inc;
      // elapsed + 1 > 1000/rate  is  (elapsed + 1) * rate > 1000
      ex_time_prod <= (TP_W'(ms_inc) + TP_W'(1)) * TP_W'(rate_eff);
    end
  end

  // Decide the result of the word
  always_comb begin
    addr    = ex_addr_base + 13'(it_index);
    elapsed = ex_time_prod > TP_W'(dupml_pkg::MS_PER_S);
    priority if (run_mode == dupml_pkg::MODE_SYNC) begin
      latch = frame_dirty && (sync_seen || elapsed);
    end else if (run_mode == dupml_pkg::MODE_TIMED) begin
      latch = elapsed;
    end else begin
      latch = 1'b0;
    end
    pix_ok     = (it_action == dupml_pkg::ACT_PIXEL) && ex_in_range && ex_idx_ok;
    has_result = pix_ok || ((it_action == dupml_pkg::ACT_TICK) && latch);
  end

  assign status.has_result = has_result;
  assign status.out_busy   = m_axis_tvalid && !m_axis_tready;

  // Update latch state on commit
  always_ff @(posedge clk) begin
    if (rst) begin
      ms_since_latch <= '0;
      frame_dirty    <= 1'b0;
      sync_seen      <= 1'b0;
    end else if (cmd.commit) begin
      unique case (it_action)
        dupml_pkg::ACT_PIXEL: begin
          if (pix_ok) frame_dirty <= 1'b1;
        end
        dupml_pkg::ACT_SYNC: begin
          sync_seen <= 1'b1;
        end
        dupml_pkg::ACT_TICK: begin
          if (latch) begin
            ms_since_latch <= '0;
            frame_dirty    <= 1'b0;
            sync_seen      <= 1'b0;
          end else begin
            ms_since_latch <= ex_ms_inc;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Output valid: set on a committed result, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.commit && has_result) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (cmd.commit && has_result) begin
      if (pix_ok) begin
        out_kind  <= dupml_pkg::KIND_PIXEL;
        out_addr  <= addr;
        out_red   <= it_red;
        out_green <= it_green;
        out_blue  <= it_blue;
      end else begin
        out_kind  <= dupml_pkg::KIND_LATCH;
        out_addr  <= '0;
        out_red   <= '0;
        out_green <= '0;
        out_blue  <= '0;
      end
    end
  end

  assign m_axis_tdata = {3'b000, out_blue, out_green, out_red, out_addr};
  assign m_axis_tuser = out_kind;

  `ASSERT_NEXT(a_latch_clears, clk, rst, cmd.commit && has_result && (it_action == dupml_pkg::ACT_TICK), (ms_since_latch == 16'd0) && !frame_dirty && !sync_seen, "latch did not clear state")
  `ASSERT_NEXT(a_pixel_dirty, clk, rst, cmd.commit && pix_ok, frame_dirty && m_axis_tvalid, "pixel write did not mark frame dirty")

endmodule

`default_nettype wire
